### rtl/afm_pkg.sv
package afm_pkg;

  // frame layout
  localparam logic [3:0] FRAME_LEN  = 4'd10;
  localparam logic [7:0] SYNC_1     = 8'hB5;
  localparam logic [7:0] SYNC_2     = 8'h62;
  localparam logic [7:0] MSG_CLASS  = 8'h05;
  localparam logic [7:0] MSG_ID     = 8'h01;
  localparam logic [7:0] LEN_LO     = 8'h02;
  localparam logic [7:0] LEN_HI     = 8'h00;

  // configuration reset values
  localparam logic [7:0]  RST_ACK_CLASS    = 8'd6;
  localparam logic [7:0]  RST_ACK_ID       = 8'd36;
  localparam logic [15:0] RST_TIMEOUT_MS   = 16'd3000;
  localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd10;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ACK_CLASS    = 2'd0,
    REG_ACK_ID       = 2'd1,
    REG_TIMEOUT_MS   = 2'd2,
    REG_MAX_ATTEMPTS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_SEND  = 2'd0,
    ST_ACK   = 2'd1,
    ST_RETRY = 2'd2,
    ST_FAIL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  ack_class;
    logic [7:0]  ack_id;
    logic [15:0] timeout_ms;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] attempt;
  } result_t;

endpackage

### rtl/afm_expect.sv
module afm_expect (
  input  logic [7:0] ack_class_i,
  input  logic [7:0] ack_id_i,
  input  logic [3:0] index_i,
  output logic [7:0] byte_o
);

  logic [7:0] ck_a;
  logic [7:0] ck_b;

  // fletcher-8 over the six body bytes, folded to closed form
  assign ck_a = afm_pkg::MSG_CLASS + afm_pkg::MSG_ID + afm_pkg::LEN_LO + afm_pkg::LEN_HI
              + ack_class_i + ack_id_i;
  assign ck_b = 8'd6 * afm_pkg::MSG_CLASS + 8'd5 * afm_pkg::MSG_ID
              + 8'd4 * afm_pkg::LEN_LO + 8'd3 * afm_pkg::LEN_HI
              + {ack_class_i[6:0], 1'b0} + ack_id_i;

  always_comb begin
    case (index_i)
      4'd0:    byte_o = afm_pkg::SYNC_1;
      4'd1:    byte_o = afm_pkg::SYNC_2;
      4'd2:    byte_o = afm_pkg::MSG_CLASS;
      4'd3:    byte_o = afm_pkg::MSG_ID;
      4'd4:    byte_o = afm_pkg::LEN_LO;
      4'd5:    byte_o = afm_pkg::LEN_HI;
      4'd6:    byte_o = ack_class_i;
      4'd7:    byte_o = ack_id_i;
      4'd8:    byte_o = ck_a;
      default: byte_o = ck_b;
    endcase
  end

endmodule

### rtl/afm_ctrl.sv
module afm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afm_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  afm_pkg::item_t    item_i,
  output logic              res_valid_o,
  output afm_pkg::result_t  res_o
);

  logic        busy_q, busy_d;
  logic [3:0]  idx_q, idx_d;
  logic [16:0] elapsed_q, elapsed_d;
  logic [3:0]  attempts_q, attempts_d;
  logic [16:0] elapsed_inc;
  logic [7:0]  exp_byte;

  afm_expect u_expect (
    .ack_class_i (cfg_i.ack_class),
    .ack_id_i    (cfg_i.ack_id),
    .index_i     (idx_q),
    .byte_o      (exp_byte)
  );

  assign elapsed_inc = elapsed_q + 17'd1;

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    elapsed_d   = elapsed_q;
    attempts_d  = attempts_q;
    res_valid_o = 1'b0;
    res_o       = '{status: afm_pkg::ST_SEND, attempt: 4'd0};
    if (item_valid_i) begin
      case (afm_pkg::op_e'(item_i.operation))
        afm_pkg::OP_START: begin
          busy_d      = 1'b1;
          attempts_d  = 4'd1;
          idx_d       = 4'd0;
          elapsed_d   = 17'd0;
          res_valid_o = 1'b1;
          res_o       = '{status: afm_pkg::ST_SEND, attempt: 4'd1};
        end
        afm_pkg::OP_BYTE: begin
          if (busy_q) begin
            if (idx_q < afm_pkg::FRAME_LEN && item_i.rx_byte == exp_byte) begin
              if (idx_q == afm_pkg::FRAME_LEN - 4'd1) begin
                busy_d      = 1'b0;
                idx_d       = 4'd0;
                res_valid_o = 1'b1;
                res_o       = '{status: afm_pkg::ST_ACK, attempt: attempts_q};
              end else begin
                idx_d = idx_q + 4'd1;
              end
            end else begin
              // mismatch: start over, this byte is not looked at again
              idx_d = 4'd0;
            end
          end
        end
        afm_pkg::OP_TICK: begin
          if (busy_q) begin
            if (elapsed_inc > {1'b0, cfg_i.timeout_ms}) begin
              idx_d       = 4'd0;
              elapsed_d   = 17'd0;
              res_valid_o = 1'b1;
              if (attempts_q < cfg_i.max_attempts) begin
                attempts_d = attempts_q + 4'd1;
                res_o      = '{status: afm_pkg::ST_RETRY, attempt: attempts_q + 4'd1};
              end else begin
                busy_d = 1'b0;
                res_o  = '{status: afm_pkg::ST_FAIL, attempt: attempts_q};
              end
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      idx_q      <= 4'd0;
      elapsed_q  <= 17'd0;
      attempts_q <= 4'd0;
    end else begin
      busy_q     <= busy_d;
      idx_q      <= idx_d;
      elapsed_q  <= elapsed_d;
      attempts_q <= attempts_d;
    end
  end

endmodule

### rtl/ack_frame_matcher_with_retry_core.sv
// acknowledge frame matcher with retry
//
// input stream: one transfer per event - start waiting, a received uart byte
// or a one millisecond tick. output stream: a status transfer whenever the
// event calls for one (send command, acknowledged, resend after timeout,
// failed after the last attempt), carrying the attempt number.
//
// an accepted transfer lands in an input register, is evaluated by the match
// and counter logic once the output register can take its result, and any
// status it produces is caught in the output register. one input transfer is
// taken every cycle while the output register is empty or being read; the
// state update in afm_ctrl adds no stall of its own.
//
// when the receiver stalls, the output register holds its result; the input
// register still takes one transfer while it is empty, and once it holds an
// item s_axis_tready_o stays low until the output register is freed.
//
// reset (rst_ni low) clears both registers' valid flags, puts the matcher
// idle and loads the configuration registers with their default values.
// configuration writes are accepted in any cycle and take effect at once.
module ack_frame_matcher_with_retry_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // event stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [1:0] operation, [9:2] rx_byte, rest zero
  // status stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] status, [5:2] attempt, rest zero
);

  afm_pkg::cfg_t    cfg_q;
  logic             in_valid_q;
  afm_pkg::item_t   in_item_q;
  logic             out_valid_q;
  afm_pkg::result_t out_res_q;

  logic             advance;
  logic             res_valid;
  afm_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_class    <= afm_pkg::RST_ACK_CLASS;
      cfg_q.ack_id       <= afm_pkg::RST_ACK_ID;
      cfg_q.timeout_ms   <= afm_pkg::RST_TIMEOUT_MS;
      cfg_q.max_attempts <= afm_pkg::RST_MAX_ATTEMPTS;
    end else if (cfg_we_i) begin
      case (afm_pkg::reg_idx_e'(cfg_idx_i))
        afm_pkg::REG_ACK_CLASS:    cfg_q.ack_class    <= cfg_wdata_i[7:0];
        afm_pkg::REG_ACK_ID:       cfg_q.ack_id       <= cfg_wdata_i[7:0];
        afm_pkg::REG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_wdata_i;
        afm_pkg::REG_MAX_ATTEMPTS: cfg_q.max_attempts <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // the held item may be evaluated once its result has somewhere to go
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.operation <= s_axis_tdata_i[1:0];
      in_item_q.rx_byte   <= s_axis_tdata_i[9:2];
    end
  end

  // matcher, timer and attempt counter
  afm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_valid_q && advance),
    .item_i       (in_item_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_res_q.attempt, out_res_q.status};

endmodule

### dv/afm_ack_checker.sv
module afm_ack_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // [1:0] operation, [9:2] rx_byte
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // [1:0] status, [5:2] attempt
  output int          fail_count_o,
  output int          pending_o
);

  afm_pkg::cfg_t    regs;
  logic             waiting;
  logic [3:0]       match_pos;
  logic [16:0]      ticks_seen;
  logic [3:0]       attempt_no;
  afm_pkg::result_t status_q[$];

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // byte the acknowledge frame carries at a given position
  function automatic logic [7:0] frame_byte(logic [3:0] pos);
    logic [7:0] body [6];
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    body  = '{afm_pkg::MSG_CLASS, afm_pkg::MSG_ID, afm_pkg::LEN_LO, afm_pkg::LEN_HI,
              regs.ack_class, regs.ack_id};
    sum_a = 8'h00;
    sum_b = 8'h00;
    for (int i = 0; i < 6; i++) begin
      sum_a = sum_a + body[i];
      sum_b = sum_b + sum_a;
    end
    case (pos)
      4'd0:    return afm_pkg::SYNC_1;
      4'd1:    return afm_pkg::SYNC_2;
      4'd8:    return sum_a;
      4'd9:    return sum_b;
      default: return body[pos - 4'd2];
    endcase
  endfunction

  // state update for one event, queueing the status it causes
  task automatic predict_status(logic [1:0] op, logic [7:0] rx);
    case (op)
      afm_pkg::OP_START: begin
        waiting    = 1'b1;
        attempt_no = 4'd1;
        match_pos  = 4'd0;
        ticks_seen = '0;
        status_q.push_back('{afm_pkg::ST_SEND, 4'd1});
      end
      afm_pkg::OP_BYTE: if (waiting) begin
        if (match_pos < afm_pkg::FRAME_LEN && rx == frame_byte(match_pos)) begin
          match_pos = match_pos + 4'd1;
          if (match_pos >= afm_pkg::FRAME_LEN) begin
            waiting   = 1'b0;
            match_pos = 4'd0;
            status_q.push_back('{afm_pkg::ST_ACK, attempt_no});
          end
        end else begin
          match_pos = 4'd0;
        end
      end
      afm_pkg::OP_TICK: if (waiting) begin
        ticks_seen = ticks_seen + 17'd1;
        if (ticks_seen > {1'b0, regs.timeout_ms}) begin
          match_pos  = 4'd0;
          ticks_seen = '0;
          if (attempt_no < regs.max_attempts) begin
            attempt_no = attempt_no + 4'd1;
            status_q.push_back('{afm_pkg::ST_RETRY, attempt_no});
          end else begin
            waiting = 1'b0;
            status_q.push_back('{afm_pkg::ST_FAIL, attempt_no});
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_status(logic [7:0] data);
    afm_pkg::result_t want;
    if (status_q.size() == 0) begin
      report_mismatch($sformatf("status transfer 0x%02h with nothing expected", data));
    end else begin
      want = status_q.pop_front();
      if (data[1:0] != want.status)
        report_mismatch($sformatf("status %0d, expected %0d", data[1:0], want.status));
      if (data[5:2] != want.attempt)
        report_mismatch($sformatf("attempt %0d, expected %0d", data[5:2], want.attempt));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs         = '{afm_pkg::RST_ACK_CLASS, afm_pkg::RST_ACK_ID,
                       afm_pkg::RST_TIMEOUT_MS, afm_pkg::RST_MAX_ATTEMPTS};
      waiting      = 1'b0;
      match_pos    = 4'd0;
      ticks_seen   = '0;
      attempt_no   = 4'd0;
      fail_count_o = 0;
      status_q.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_status(m_tdata_i);
      if (s_tvalid_i && s_tready_i) predict_status(s_tdata_i[1:0], s_tdata_i[9:2]);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          afm_pkg::REG_ACK_CLASS:    regs.ack_class    = cfg_wdata_i[7:0];
          afm_pkg::REG_ACK_ID:       regs.ack_id       = cfg_wdata_i[7:0];
          afm_pkg::REG_TIMEOUT_MS:   regs.timeout_ms   = cfg_wdata_i;
          afm_pkg::REG_MAX_ATTEMPTS: regs.max_attempts = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      pending_o <= status_q.size();
    end
  end

endmodule

### dv/tb_ack_frame_matcher_with_retry_core.sv
module tb_ack_frame_matcher_with_retry_core;

  // operation code the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 56;
  // two-stage pipeline, plus some margin
  localparam int SETTLE_CYCLES   = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = afm_pkg::REG_ACK_CLASS;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [1:0] operation, [9:2] rx_byte, rest zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [1:0] status, [5:2] attempt, rest zero

  int fail_count;
  int pending_status;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  // frame the block currently waits for, rebuilt whenever class or id change
  logic [7:0] ack_frame [10];

  always #1 clk_i = ~clk_i;

  ack_frame_matcher_with_retry_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  afm_ack_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_status)
  );

  // status receiver: stalls at random with the current stall rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one event transfer; valid stays high afterwards so back-to-back
  // transfers need no second assignment in the same step
  task automatic put_event(logic [1:0] op, logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, rx, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // wait until every expected status has gone out and the pipeline is empty
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    // the count seen at the last transfer's edge does not yet include it
    @(posedge clk_i);
    while (pending_status != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all four registers in a row, then rebuild the expected frame
  task automatic program_regs(logic [7:0] cls, logic [7:0] id, logic [15:0] tmo,
                              logic [3:0] max_att);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= afm_pkg::REG_ACK_CLASS;
    cfg_wdata_i <= {8'h00, cls};
    @(posedge clk_i);
    cfg_idx_i   <= afm_pkg::REG_ACK_ID;
    cfg_wdata_i <= {8'h00, id};
    @(posedge clk_i);
    cfg_idx_i   <= afm_pkg::REG_TIMEOUT_MS;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i   <= afm_pkg::REG_MAX_ATTEMPTS;
    cfg_wdata_i <= {12'h000, max_att};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ack_frame = '{afm_pkg::SYNC_1, afm_pkg::SYNC_2, afm_pkg::MSG_CLASS, afm_pkg::MSG_ID,
                  afm_pkg::LEN_LO, afm_pkg::LEN_HI, cls, id, 8'h00, 8'h00};
    ck_a = 8'h00;
    ck_b = 8'h00;
    for (int i = 2; i < 8; i++) begin
      ck_a = ck_a + ack_frame[i];
      ck_b = ck_b + ck_a;
    end
    ack_frame[8] = ck_a;
    ack_frame[9] = ck_b;
  endtask

  // acknowledge frame with the odd corrupted byte and stray ticks in between
  task automatic send_frame(int damage_pct, int tick_pct);
    for (int pos = 0; pos < 10; pos++) begin
      if ($urandom_range(99) < tick_pct)
        put_event(afm_pkg::OP_TICK, 8'($urandom_range(255)));
      if ($urandom_range(99) < damage_pct)
        put_event(afm_pkg::OP_BYTE, 8'($urandom_range(255)));
      else
        put_event(afm_pkg::OP_BYTE, ack_frame[pos]);
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1:       begin send_idle_pct = 70; recv_stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct <= 70; end
      default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
    endcase
  endtask

  initial begin
    int pick;
    int phase_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset register values ----
    program_regs(afm_pkg::RST_ACK_CLASS, afm_pkg::RST_ACK_ID, afm_pkg::RST_TIMEOUT_MS,
                 afm_pkg::RST_MAX_ATTEMPTS);
    // events while idle are dropped
    put_event(afm_pkg::OP_BYTE, 8'hB5);
    put_event(afm_pkg::OP_TICK, 8'h00);
    put_event(OP_UNUSED, 8'hFF);
    put_event(afm_pkg::OP_START, 8'h00);
    put_event(OP_UNUSED, 8'h00);
    // second sync byte mismatches and is not taken as a fresh first byte
    put_event(afm_pkg::OP_BYTE, 8'hB5);
    put_event(afm_pkg::OP_BYTE, 8'hB5);
    put_event(afm_pkg::OP_BYTE, 8'h62);
    // restart in the middle of a frame, then a clean frame
    put_event(afm_pkg::OP_BYTE, 8'hB5);
    put_event(afm_pkg::OP_START, 8'h00);
    send_frame(0, 0);
    drain;

    // zero timeout and zero attempts: the first tick already fails
    program_regs(8'hFF, 8'h00, 16'd0, 4'd0);
    put_event(afm_pkg::OP_START, 8'h00);
    put_event(afm_pkg::OP_TICK, 8'h00);
    drain;

    // one retry, then failure
    program_regs(8'h00, 8'hFF, 16'd1, 4'd2);
    put_event(afm_pkg::OP_START, 8'h00);
    repeat (4) put_event(afm_pkg::OP_TICK, 8'h00);
    drain;

    // ---- random part, several register settings and idling phases ----
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_regs(8'h00, 8'h00, 16'd1, 4'd15);
        1: program_regs(8'hFF, 8'hFF, 16'hFFFF, 4'd1);
        2: program_regs(afm_pkg::RST_ACK_CLASS, afm_pkg::RST_ACK_ID, 16'd3,
                        afm_pkg::RST_MAX_ATTEMPTS);
        3: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd1, 4'd1);
        default: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                              16'($urandom_range(1, 8)), 4'($urandom_range(1, 15)));
      endcase
      set_idling(p % 4);
      phase_end = items_sent + ITEMS_PER_PHASE;
      put_event(afm_pkg::OP_START, 8'($urandom_range(255)));
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // mostly well-formed frames, now and then after a fresh start
          if ($urandom_range(3) == 0) put_event(afm_pkg::OP_START, 8'($urandom_range(255)));
          send_frame(5, 10);
        end else if (pick < 70) begin
          // tick bursts drive retries and failures
          repeat ($urandom_range(1, 10)) put_event(afm_pkg::OP_TICK, 8'($urandom_range(255)));
        end else if (pick < 85) begin
          // noise: any operation code with any byte
          put_event(2'($urandom_range(3)), 8'($urandom_range(255)));
        end else begin
          put_event(afm_pkg::OP_START, 8'($urandom_range(255)));
        end
      end
      drain;
    end

    if (fail_count == 0 && pending_status == 0) begin
      $display("** ack_frame_matcher_with_retry_core: PASSED **");
    end else begin
      $display("** ack_frame_matcher_with_retry_core: FAILED **");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2000000;
    $display("** ack_frame_matcher_with_retry_core: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/afm_pkg.sv
rtl/afm_expect.sv
rtl/afm_ctrl.sv
rtl/ack_frame_matcher_with_retry_core.sv
dv/afm_ack_checker.sv
dv/tb_ack_frame_matcher_with_retry_core.sv
